[rtl/core/sbus_frame_encoder_defines.svh]
// Assertion macros for the SBUS frame encoder.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef SBUS_FRAME_ENCODER_DEFINES_SVH
`define SBUS_FRAME_ENCODER_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset.
`define SFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sfe_pkg.sv]
// Shared constants and types for the SBUS frame encoder.
// No dependencies; used by all modules of the encoder.
`timescale 1ns / 1ps

package sfe_pkg;

    localparam int          VALUE_BITS  = 11;
    localparam int          DATA_BYTES  = 22;
    localparam int          FRAME_BYTES = 25;
    localparam int          IDX_BITS    = 5;

    localparam logic [7:0]  SBUS_START    = 8'h0F;
    localparam logic [7:0]  SBUS_ZERO     = 8'h00;
    localparam logic [11:0] CMD_OFFSET    = 12'd880;
    localparam logic [15:0] RECIP_FIVE    = 16'd52429;  // ceil(2^18 / 5)
    localparam int          RECIP_SHIFT   = 18;
    localparam logic [7:0]  DIVIDER_RESET = 8'd4;

    // Input action carried in tuser.
    localparam logic        ACT_WRITE     = 1'b0;
    localparam logic        ACT_TICK      = 1'b1;

    localparam logic [IDX_BITS-1:0] IDX_START      = 5'd0;
    localparam logic [IDX_BITS-1:0] IDX_FIRST_DATA = 5'd1;
    localparam logic [IDX_BITS-1:0] IDX_LAST_DATA  = 5'd22;
    localparam logic [IDX_BITS-1:0] IDX_END        = 5'd24;

    // Control from the frame sequencer to every cell of the chain.
    typedef struct packed {
        logic load;   // copy the stored channel value into the shift stage
        logic shift;  // move the chain down by one byte
    } chain_ctrl_t;

endpackage

[rtl/core/sfe_scaler.sv]
// Command to SBUS value conversion: floor((cmd - 880) * 8 / 5), low 11 bits; zero below 880.
// Depends on sfe_pkg.
`timescale 1ns / 1ps

module sfe_scaler
(
    input  logic [11:0]                  command,
    output logic [sfe_pkg::VALUE_BITS-1:0] value
);

    logic [11:0] diff;
    logic [14:0] times8;
    logic [30:0] prod;

    always_comb
    begin
        diff   = command - sfe_pkg::CMD_OFFSET;
        times8 = {diff, 3'b000};
        // Division by five as a multiply by the rounded-up reciprocal; exact for x < 2^18.
        prod   = 31'(times8) * 31'(sfe_pkg::RECIP_FIVE);
        if (command < sfe_pkg::CMD_OFFSET)
        begin
            value = '0;
        end
        else
        begin
            value = prod[sfe_pkg::RECIP_SHIFT +: sfe_pkg::VALUE_BITS];
        end
    end

endmodule

[rtl/core/sfe_cell.sv]
// One channel cell: holds the scaled channel value and one slice of the frame shift chain.
// Depends on sfe_pkg.
`timescale 1ns / 1ps

module sfe_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  sfe_pkg::chain_ctrl_t             ctrl,
    input  logic                             wr_en,
    input  logic [sfe_pkg::VALUE_BITS-1:0]   wr_value,
    input  logic [7:0]                       shift_in,
    output logic [7:0]                       shift_out
);

    logic [sfe_pkg::VALUE_BITS-1:0] value_reg;
    logic [sfe_pkg::VALUE_BITS-1:0] value_next;
    logic [sfe_pkg::VALUE_BITS-1:0] shift_reg;
    logic [sfe_pkg::VALUE_BITS-1:0] shift_next;

    always_comb
    begin
        value_next = wr_en ? wr_value : value_reg;
        shift_next = shift_reg;
        if (ctrl.load)
        begin
            shift_next = value_reg;
        end
        else if (ctrl.shift)
        begin
            // Bits move one byte toward cell 0; the neighbor's low byte fills the top.
            shift_next = {shift_in, shift_reg[sfe_pkg::VALUE_BITS-1:8]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign shift_out = shift_reg[7:0];

endmodule

[rtl/core/sbus_frame_encoder.sv]
// Top level of the SBUS frame encoder: stream ports, tick counter and frame sequencer.
// Depends on sfe_pkg, sfe_scaler, sfe_cell and sbus_frame_encoder_defines.svh.
//
//  Channel | Direction | Signals                         | Contents
//  --------+-----------+---------------------------------+-------------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser | channel write or tick
//  m_*     | out       | m_tvalid m_tready m_tdata m_tlast | frame bytes, tlast on end byte
//  cfg_*   | in        | cfg_valid cfg_ready cfg_data      | tick_divider
//
// A command write updates a channel value. A tick advances the tick counter, and a tick
// that reaches the divider starts a frame of 25 bytes that leaves at one byte per cycle
// while m_tready is high, set by the byte index register and the one-byte shift of the cell
// chain per data byte taken. The input reopens in the cycle after the end byte is taken.
// Reset is asynchronous and active low; it clears the channel values, the tick counter
// and restores the divider to 4. While a frame is being sent the input channel is
// stalled; a stalled output transaction holds its byte and the chain position.
`timescale 1ns / 1ps
`include "sbus_frame_encoder_defines.svh"

module sbus_frame_encoder
#(
    parameter int CHANNELS = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] channel, [15:4] command
    input  logic        s_tuser,   // [0] action: 0 command write, 1 tick
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast,   // last_byte
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [7:0] tick_divider
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [sfe_pkg::IDX_BITS-1:0]    idx_reg;
    logic [sfe_pkg::IDX_BITS-1:0]    idx_next;
    logic [7:0]                      count_reg;
    logic [7:0]                      count_next;
    logic [7:0]                      divider_reg;
    logic [7:0]                      divider_next;

    logic [3:0]                      in_channel;
    logic [11:0]                     in_command;
    logic                            in_accept;
    logic                            out_accept;
    logic                            wr_accept;
    logic [7:0]                      count_inc;
    logic                            frame_start;
    logic [sfe_pkg::VALUE_BITS-1:0]  scaled;
    sfe_pkg::chain_ctrl_t            ctrl;
    logic [7:0]                      link [CHANNELS];

    assign in_channel = s_tdata[3:0];
    assign in_command = s_tdata[15:4];

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;

    // Writes to channels beyond the chain are dropped.
    assign wr_accept   = in_accept && (s_tuser == sfe_pkg::ACT_WRITE)
                         && ({1'b0, in_channel} < 5'(CHANNELS));
    assign count_inc   = count_reg + 8'd1;
    assign frame_start = in_accept && (s_tuser == sfe_pkg::ACT_TICK)
                         && (count_inc == divider_reg);

    sfe_scaler u_scaler
    (
        .command (in_command),
        .value   (scaled)
    );

    // The chain is loaded at frame start and moves one byte on every data byte taken.
    always_comb
    begin
        ctrl.load  = frame_start;
        ctrl.shift = out_accept && (idx_reg >= sfe_pkg::IDX_FIRST_DATA)
                     && (idx_reg <= sfe_pkg::IDX_LAST_DATA);
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        logic [7:0] neighbor;
        if (i == CHANNELS - 1)
        begin : g_tail
            assign neighbor = 8'h00;
        end
        else
        begin : g_body
            assign neighbor = link[i + 1];
        end

        sfe_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_en     (wr_accept && (in_channel == 4'(i))),
            .wr_value  (scaled),
            .shift_in  (neighbor),
            .shift_out (link[i])
        );
    end

    // Next-state logic of the tick counter and the frame sequencer.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        divider_next = divider_reg;

        if (cfg_valid && cfg_ready)
        begin
            divider_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == sfe_pkg::ACT_TICK))
                begin
                    count_next = count_inc;
                    if (frame_start)
                    begin
                        count_next = 8'd0;
                        idx_next   = sfe_pkg::IDX_START;
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                if (out_accept)
                begin
                    if (idx_reg == sfe_pkg::IDX_END)
                    begin
                        idx_next   = sfe_pkg::IDX_START;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= sfe_pkg::IDX_START;
            count_reg   <= 8'd0;
            divider_reg <= sfe_pkg::DIVIDER_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            divider_reg <= divider_next;
        end
    end

    // Byte selection: start byte, the low byte of cell 0 for data, zero for flags and end.
    always_comb
    begin
        case (idx_reg) inside
            sfe_pkg::IDX_START:                               m_tdata = sfe_pkg::SBUS_START;
            [sfe_pkg::IDX_FIRST_DATA:sfe_pkg::IDX_LAST_DATA]: m_tdata = link[0];
            default:                                          m_tdata = sfe_pkg::SBUS_ZERO;
        endcase
    end

    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tlast  = (idx_reg == sfe_pkg::IDX_END);

    // The input side is never open while a frame is in flight.
    `SFE_ASSERT_IMP(a_exclusive, s_tready, !m_tvalid, "input open during a frame")
    // A tick that reaches the divider is followed by the start byte.
    `SFE_ASSERT_NXT(a_frame_start, frame_start,
        m_tvalid && (m_tdata == sfe_pkg::SBUS_START), "frame did not start")
    // The end byte closes the frame and reopens the input.
    `SFE_ASSERT_NXT(a_frame_end, out_accept && m_tlast,
        s_tready && (count_reg == 8'd0), "frame did not close")
    // The counter does not move while bytes are being sent.
    `SFE_ASSERT_NXT(a_count_hold, m_tvalid, $stable(count_reg) || s_tready,
        "tick counter moved during a frame")

endmodule
